>>> src/ptbf_pkg.sv
// shared constants and helpers for the period to bcd frequency block
// no dependencies
package ptbf_pkg;

	// frequency in hundredths of a hertz is this over whole microseconds
	localparam int unsigned NUM_BITS = 27;
	localparam logic [NUM_BITS-1:0] HUND_PER_SEC_US = 27'd100000000;

	// quotient bits needed once the microsecond count is above the limit
	localparam int unsigned QUOT_BITS = 20;

	// at or below this many microseconds the result clamps
	localparam int unsigned SAT_US = 100;

	localparam int unsigned BCD_DIGITS = 6;
	localparam int unsigned BCD_BITS = 4 * BCD_DIGITS;
	localparam logic [BCD_BITS-1:0] BCD_ALL_NINES = 24'h999999;

	localparam logic [7:0] TPM_RESET = 8'd6;

	// queue between front and back
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_BITS = 2;
	localparam int unsigned FIFO_CNT_BITS = 3;

	// double dabble correction: add three to every digit of five or more
	function automatic logic [BCD_BITS-1:0] bcd_adjust(input logic [BCD_BITS-1:0] bcd);
		logic [BCD_BITS-1:0] res;
		logic [3:0] dig;
		res = bcd;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			dig = bcd[4*i +: 4];
			if (dig >= 4'd5) begin
				res[4*i +: 4] = dig + 4'd3;
			end
		end
		return res;
	endfunction

endpackage

>>> src/ptbf_front.sv
// front part: period to whole microseconds, one quotient bit per stage,
// plus classification of clamped results; uses ptbf_pkg
module ptbf_front import ptbf_pkg::*; #(
	parameter int unsigned PERIOD_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [15:0]            period_ticks,
	input  logic [7:0]             tpm,
	input  logic                   q_full,
	output logic                   push,
	output logic [PERIOD_BITS-1:0] us,
	output logic                   sat
);

	localparam int unsigned PB = PERIOD_BITS;

	logic          v_s [PB];
	logic [PB-1:0] x_s [PB];
	logic [7:0]    r_s [PB];
	logic          z_s [PB];
	logic [31:0]   period_ext;
	logic          en;

	assign period_ext = {16'b0, period_ticks};

	// whole pipeline moves unless its last beat is blocked by a full queue
	assign en       = !v_s[PB-1] || !q_full;
	assign in_stall = !en;
	assign push     = v_s[PB-1] && !q_full;

	genvar k;
	generate
		for (k = 0; k < PB; k++) begin : g_stage
			logic          pv;
			logic [PB-1:0] px;
			logic [7:0]    pr;
			logic          pz;
			logic [8:0]    t;
			logic          qb;

			if (k == 0) begin : g_first
				assign pv = in_valid;
				assign px = period_ext[PB-1:0];
				assign pr = 8'd0;
				assign pz = (tpm == 8'd0);
			end else begin : g_next
				assign pv = v_s[k-1];
				assign px = x_s[k-1];
				assign pr = r_s[k-1];
				assign pz = z_s[k-1];
			end

			// one restoring division step
			assign t  = {pr, px[PB-1]};
			assign qb = (t >= {1'b0, tpm});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en) begin
					v_s[k] <= pv;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					x_s[k] <= {px[PB-2:0], qb};
					r_s[k] <= qb ? 8'(t - {1'b0, tpm}) : t[7:0];
					z_s[k] <= pz;
				end
			end
		end
	endgenerate

	// classify: zero divisor, zero microseconds or too high a frequency
	assign us  = x_s[PB-1];
	assign sat = z_s[PB-1] || (x_s[PB-1] <= PB'(SAT_US));

endmodule

>>> src/ptbf_fifo.sv
// short queue between front and back parts
// uses ptbf_pkg for depth constants
module ptbf_fifo import ptbf_pkg::*; #(
	parameter int unsigned WIDTH = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0]         mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] cnt_q;

	assign full      = (cnt_q == FIFO_CNT_BITS'(FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
		else $error("queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

endmodule

>>> src/ptbf_back.sv
// back part: reciprocal division one bit per stage, then binary to bcd
// one bit per stage; uses ptbf_pkg
module ptbf_back import ptbf_pkg::*; #(
	parameter int unsigned PERIOD_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_avail,
	output logic                   pop,
	input  logic [PERIOD_BITS-1:0] us,
	input  logic                   sat,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [BCD_BITS-1:0]    bcd_frequency,
	output logic                   saturated
);

	localparam int unsigned PB = PERIOD_BITS;
	localparam int unsigned QB = QUOT_BITS;

	logic          dv_s [QB];
	logic [PB-1:0] dr_s [QB];
	logic [QB-1:0] dq_s [QB];
	logic [PB-1:0] dus_s [QB];
	logic          dsat_s [QB];

	logic                bv_s [QB];
	logic [BCD_BITS-1:0] bcd_s [QB];
	logic [QB-1:0]       bin_s [QB];
	logic                bsat_s [QB];

	logic en;

	assign en  = !bv_s[QB-1] || !out_stall;
	assign pop = in_avail && en;

	genvar k;
	generate
		// reciprocal divider: numerator bits are constants
		for (k = 0; k < QB; k++) begin : g_div
			logic          pv;
			logic [PB-1:0] pr;
			logic [QB-1:0] pq;
			logic [PB-1:0] pus;
			logic          psat;
			logic [PB:0]   t;
			logic          qb;

			if (k == 0) begin : g_first
				assign pv   = pop;
				assign pr   = PB'(HUND_PER_SEC_US >> QB);
				assign pq   = '0;
				assign pus  = us;
				assign psat = sat;
			end else begin : g_next
				assign pv   = dv_s[k-1];
				assign pr   = dr_s[k-1];
				assign pq   = dq_s[k-1];
				assign pus  = dus_s[k-1];
				assign psat = dsat_s[k-1];
			end

			assign t  = {pr, HUND_PER_SEC_US[QB-1-k]};
			assign qb = (t >= {1'b0, pus});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_s[k] <= 1'b0;
				end else if (en) begin
					dv_s[k] <= pv;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dr_s[k]   <= qb ? PB'(t - {1'b0, pus}) : t[PB-1:0];
					dq_s[k]   <= {pq[QB-2:0], qb};
					dus_s[k]  <= pus;
					dsat_s[k] <= psat;
				end
			end
		end

		// double dabble, one binary bit per stage
		for (k = 0; k < QB; k++) begin : g_bcd
			logic                pv;
			logic [BCD_BITS-1:0] pb;
			logic [QB-1:0]       pbin;
			logic                psat;
			logic [BCD_BITS-1:0] adj;

			if (k == 0) begin : g_first
				assign pv   = dv_s[QB-1];
				assign pb   = '0;
				assign pbin = dq_s[QB-1];
				assign psat = dsat_s[QB-1];
			end else begin : g_next
				assign pv   = bv_s[k-1];
				assign pb   = bcd_s[k-1];
				assign pbin = bin_s[k-1];
				assign psat = bsat_s[k-1];
			end

			assign adj = bcd_adjust(pb);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					bv_s[k] <= 1'b0;
				end else if (en) begin
					bv_s[k] <= pv;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					bcd_s[k]  <= {adj[BCD_BITS-2:0], pbin[QB-1]};
					bin_s[k]  <= {pbin[QB-2:0], 1'b0};
					bsat_s[k] <= psat;
				end
			end
		end
	endgenerate

	// result beat
	assign out_valid     = bv_s[QB-1];
	assign saturated     = bsat_s[QB-1];
	assign bcd_frequency = bsat_s[QB-1] ? BCD_ALL_NINES : bcd_s[QB-1];

	a_digits_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !saturated) |->
		(bcd_frequency[23:20] <= 4'd9 && bcd_frequency[19:16] <= 4'd9 &&
		 bcd_frequency[15:12] <= 4'd9 && bcd_frequency[11:8] <= 4'd9 &&
		 bcd_frequency[7:4] <= 4'd9 && bcd_frequency[3:0] <= 4'd9))
		else $error("non decimal digit in result");

	a_pop_moves: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> dv_s[0])
		else $error("popped beat lost");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");

endmodule

>>> src/period_to_bcd_frequency_top.sv
// Period to BCD frequency meter. Each period beat (timer ticks) is divided by
// ticks_per_microsecond, then 100000000 is divided by the microsecond count and
// the hundredths-of-hertz result is given as six packed BCD digits. Results at
// or above 10000.00 Hz, below one microsecond or from a zero divisor read
// 999999 with saturated set. One beat is taken every cycle unless in_stall is
// raised; beats pass the two bit-per-stage dividers with the four-entry queue
// between them, then the bit-per-stage BCD converter. The divisor register is
// written with cfg_wr_en and should only change while no beat is in flight.
module period_to_bcd_frequency_top import ptbf_pkg::*; #(
	parameter int unsigned PERIOD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] period_ticks,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] bcd_frequency,
	output logic        saturated
);

	logic [7:0]             tpm_q;
	logic                   q_full;
	logic                   push;
	logic [PERIOD_BITS-1:0] us;
	logic                   sat;
	logic                   q_avail;
	logic                   pop;
	logic [PERIOD_BITS:0]   q_rd;

	// divisor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q <= TPM_RESET;
		end else if (cfg_wr_en) begin
			tpm_q <= cfg_wr_data;
		end
	end

	ptbf_front #(.PERIOD_BITS(PERIOD_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.period_ticks (period_ticks),
		.tpm          (tpm_q),
		.q_full       (q_full),
		.push         (push),
		.us           (us),
		.sat          (sat)
	);

	ptbf_fifo #(.WIDTH(PERIOD_BITS + 1)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   ({sat, us}),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_avail),
		.rd_data   (q_rd)
	);

	ptbf_back #(.PERIOD_BITS(PERIOD_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_avail      (q_avail),
		.pop           (pop),
		.us            (q_rd[PERIOD_BITS-1:0]),
		.sat           (q_rd[PERIOD_BITS]),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.bcd_frequency (bcd_frequency),
		.saturated     (saturated)
	);

endmodule
